>>> sv/clnb_pkg.sv
// Shared types, codes and helpers for the character LCD nibble bus sequencer
`timescale 1ns / 1ps

package clnb_pkg;

  // request codes on the input channel
  typedef enum logic [2:0] {
    CMD_INSTR  = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_BUSY   = 3'd4
  } cmd_t;

  // configuration register indexes
  localparam int CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] REG_PULSE_HOLD = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_CLEAR_HOLD = 1'b1;

  localparam logic [15:0] HOLD_RESET   = 16'd3200;
  localparam logic [7:0]  CLEAR_INSTR  = 8'h01;
  localparam logic [7:0]  CURSOR_BASE  = 8'h80;

  // kind of pin phase run started by a transfer
  typedef enum logic [1:0] {
    RUN_POLL,
    RUN_WRITE,
    RUN_WRITE_CLEAR
  } run_kind_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] column;
    logic       busy_req;
  } in_item_t;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic        enable;
    logic [5:0]  data_pins;
    logic        busy_pin_input;
    logic [15:0] hold_ticks;
    logic        last;
  } out_item_t;

  // request waiting for the busy flag to drop
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       is_data;
    logic       is_clear;
  } pending_t;

  // run descriptor handed from the decoder to the phase sequencer
  typedef struct packed {
    logic       emit;
    run_kind_t  kind;
    logic       rs;
    logic [7:0] data_byte;
  } run_desc_t;

  // nibble bits 3,2,1,0 go to pins 0,3,4,5
  function automatic logic [5:0] nibble_to_pins(input logic [3:0] n);
    nibble_to_pins = {n[0], n[1], n[2], 2'b00, n[3]};
  endfunction

endpackage

>>> sv/clnb_decode.sv
// Request decoder: turns one transfer and the pending request into a run and new pending state
`timescale 1ns / 1ps

module clnb_decode (
  input  clnb_pkg::in_item_t  item,
  input  clnb_pkg::pending_t  pend,
  output clnb_pkg::run_desc_t desc,
  output clnb_pkg::pending_t  pend_nxt
);
  import clnb_pkg::*;

  logic [7:0] cursor_byte;
  logic       cursor_ok;

  // cursor instruction from row and column
  assign cursor_byte = CURSOR_BASE | {1'b0, item.row[0], 2'b00, item.column[3:0]};
  assign cursor_ok   = (item.row <= 2'd1) && (item.column <= 6'd15);

  always_comb begin
    desc     = '{emit: 1'b0, kind: RUN_POLL, rs: 1'b0, data_byte: 8'h00};
    pend_nxt = pend;
    case (item.command)
      CMD_INSTR, CMD_DATA, CMD_CURSOR, CMD_CLEAR: begin
        // a new request only when none is waiting
        if (!pend.valid && (item.command != CMD_CURSOR || cursor_ok)) begin
          desc.emit         = 1'b1;
          desc.kind         = RUN_POLL;
          pend_nxt.valid    = 1'b1;
          pend_nxt.is_data  = (item.command == CMD_DATA);
          pend_nxt.is_clear = (item.command == CMD_CLEAR);
          if (item.command == CMD_CURSOR) begin
            pend_nxt.data_byte = cursor_byte;
          end else if (item.command == CMD_CLEAR) begin
            pend_nxt.data_byte = CLEAR_INSTR;
          end else begin
            pend_nxt.data_byte = item.value;
          end
        end
      end
      CMD_BUSY: begin
        // busy sample: poll again, or send the byte and go idle
        if (pend.valid) begin
          desc.emit = 1'b1;
          if (item.busy_req) begin
            desc.kind = RUN_POLL;
          end else begin
            desc.kind      = pend.is_clear ? RUN_WRITE_CLEAR : RUN_WRITE;
            desc.rs        = pend.is_data;
            desc.data_byte = pend.data_byte;
            pend_nxt       = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/char_lcd_nibble_bus_sequencer_top.sv
// Top level of the character LCD nibble bus sequencer
`timescale 1ns / 1ps

// Each transfer on the input channel produces a run of pin phases on the output
// channel, one per cycle unless out_stall holds it: a request or a busy sample
// at 1 gives two (busy poll), a busy sample at 0 gives four, or five after a
// clear; ignored transfers give none. The next input transfer is taken in the
// cycle the current run loads its final phase into the single output register,
// so the runs of back-to-back transfers follow on without a gap.
// Hold times come from the pulse and clear hold registers, both 3200 at reset.
module char_lcd_nibble_bus_sequencer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  clnb_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output clnb_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [clnb_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);
  import clnb_pkg::*;

  logic [15:0] pulse_hold_r;
  logic [15:0] clear_hold_r;
  pending_t    pend_r;
  pending_t    pend_nxt;
  run_desc_t   desc;
  run_desc_t   run_r;
  logic        run_valid_r;
  logic [2:0]  phase_r;
  logic        out_valid_r;
  out_item_t   out_r;
  out_item_t   phase_item;
  logic        in_acc;
  logic        load;
  logic        at_last;
  logic [5:0]  hi_pins;
  logic [5:0]  lo_pins;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_hold_r <= HOLD_RESET;
      clear_hold_r <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_HOLD: pulse_hold_r <= cfg_data;
        REG_CLEAR_HOLD: clear_hold_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  clnb_decode u_decode (
    .item     (in_data),
    .pend     (pend_r),
    .desc     (desc),
    .pend_nxt (pend_nxt)
  );

  // handshake control
  assign load     = run_valid_r && (!out_valid_r || !out_stall);
  assign at_last  = (run_r.kind == RUN_POLL)  ? (phase_r == 3'd1) :
                    (run_r.kind == RUN_WRITE) ? (phase_r == 3'd3) : (phase_r == 3'd4);
  assign in_stall = run_valid_r && !(load && at_last);
  assign in_acc   = in_valid && !in_stall;

  // pending request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc) begin
      pend_r <= pend_nxt;
    end
  end

  // run register and phase counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      phase_r     <= 3'd0;
    end else if (in_acc && desc.emit) begin
      run_valid_r <= 1'b1;
      phase_r     <= 3'd0;
    end else if (load) begin
      if (at_last) begin
        run_valid_r <= 1'b0;
        phase_r     <= 3'd0;
      end else begin
        phase_r     <= phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && desc.emit) begin
      run_r <= desc;
    end
  end

  // pin levels of the current phase
  assign hi_pins = nibble_to_pins(run_r.data_byte[7:4]);
  assign lo_pins = nibble_to_pins(run_r.data_byte[3:0]);

  always_comb begin
    phase_item = '0;
    if (run_r.kind == RUN_POLL) begin
      phase_item.rw             = 1'b1;
      phase_item.busy_pin_input = 1'b1;
      phase_item.enable         = phase_r[0];
      phase_item.hold_ticks     = phase_r[0] ? 16'd0 : pulse_hold_r;
      phase_item.last           = phase_r[0];
    end else begin
      phase_item.rs = run_r.rs;
      case (phase_r)
        3'd0: begin
          phase_item.enable     = 1'b1;
          phase_item.data_pins  = hi_pins;
          phase_item.hold_ticks = pulse_hold_r;
        end
        3'd1: begin
          phase_item.data_pins  = hi_pins;
        end
        3'd2: begin
          phase_item.enable     = 1'b1;
          phase_item.data_pins  = lo_pins;
          phase_item.hold_ticks = pulse_hold_r;
        end
        3'd3: begin
          phase_item.data_pins  = lo_pins;
          phase_item.last       = (run_r.kind == RUN_WRITE);
        end
        default: begin
          // trailing wait after clear display
          phase_item.data_pins  = lo_pins;
          phase_item.hold_ticks = clear_hold_r;
          phase_item.last       = 1'b1;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= phase_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
